>>> sv/leb_pkg.sv
// Package for the line edit buffer: key codes, command and state types.
// Used by leb_front, leb_queue, leb_back, the top level and the testbench; depends on nothing.

package leb_pkg;

  localparam int LINE_CAPACITY_DEF = 64;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [7:0] KEY_PREFIX = 8'd224;
  localparam logic [7:0] KEY_ESC    = 8'd27;
  localparam logic [7:0] KEY_BACK   = 8'd8;
  localparam logic [7:0] EXT_LEFT   = 8'd75;
  localparam logic [7:0] EXT_RIGHT  = 8'd77;
  localparam logic [7:0] EXT_INSERT = 8'd82;
  localparam logic [7:0] EXT_DELETE = 8'd83;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LEFT,
    OP_RIGHT,
    OP_TOGGLE,
    OP_DELETE,
    OP_BACK,
    OP_TYPE,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_EM_RD,
    S_EM_OUT,
    S_STATUS
  } state_t;

endpackage

>>> sv/leb_front.sv
// Front end of the line edit buffer: accepts key bytes and turns them into commands.
// Tracks the extended-key prefix. Depends on leb_pkg.

module leb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // key_byte[7:0]
  input  logic              push_ready,
  output logic              push_valid,
  output leb_pkg::cmd_t     push_cmd
);

  logic prefix;
  logic prefix_next;
  logic accept;

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign accept     = s_tvalid && push_ready;

  always_comb begin
    push_cmd.ch = s_tdata;
    push_cmd.op = leb_pkg::OP_NONE;
    prefix_next = prefix;
    if (prefix) begin
      prefix_next = 1'b0;
      case (s_tdata)
        leb_pkg::EXT_LEFT:   push_cmd.op = leb_pkg::OP_LEFT;
        leb_pkg::EXT_RIGHT:  push_cmd.op = leb_pkg::OP_RIGHT;
        leb_pkg::EXT_INSERT: push_cmd.op = leb_pkg::OP_TOGGLE;
        leb_pkg::EXT_DELETE: push_cmd.op = leb_pkg::OP_DELETE;
        default:             push_cmd.op = leb_pkg::OP_NONE;
      endcase
    end else if (s_tdata == leb_pkg::KEY_PREFIX) begin
      prefix_next = 1'b1;
    end else if (s_tdata == leb_pkg::KEY_ESC) begin
      push_cmd.op = leb_pkg::OP_EMIT;
    end else if (s_tdata == leb_pkg::KEY_BACK) begin
      push_cmd.op = leb_pkg::OP_BACK;
    end else if (s_tdata >= leb_pkg::PRINT_LOW && s_tdata <= leb_pkg::PRINT_HIGH) begin
      push_cmd.op = leb_pkg::OP_TYPE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= 1'b0;
    end else if (accept) begin
      prefix <= prefix_next;
    end
  end

endmodule

>>> sv/leb_queue.sv
// Command queue between front and back end of the line edit buffer.
// Small register FIFO of leb_pkg::cmd_t words. Depends on leb_pkg.

module leb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  leb_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output leb_pkg::cmd_t pop_cmd
);

  localparam int DEPTH = leb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  leb_pkg::cmd_t    entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/leb_back.sv
// Back end of the line edit buffer: line store, cursor, length, mode, result register.
// Executes queued commands, shifting the store one entry per step. Depends on leb_pkg.

module leb_back #(
  parameter int LINE_CAPACITY = leb_pkg::LINE_CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  leb_pkg::cmd_t q_cmd,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [23:0]   m_tdata,   // char_out[7:0], cursor_pos[14:8],
                                   // line_length[21:15], shift_insert[22], zero[23]
  output logic          m_tlast,   // is_last
  output logic [0:0]    m_tuser    // line_char_valid[0]
);

  localparam int IW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int PW = $clog2(LINE_CAPACITY + 1);
  localparam logic [PW-1:0] CAP = PW'(LINE_CAPACITY);

  logic [7:0] line_store [LINE_CAPACITY];
  logic [7:0] rdata;

  leb_pkg::state_t state, state_next;
  logic [PW-1:0] cursor, cursor_next;
  logic [PW-1:0] length, length_next;
  logic          ins_mode, ins_mode_next;
  logic [PW-1:0] j, j_next;
  logic [PW-1:0] emit_len, emit_len_next;
  logic [7:0]    ch_hold, ch_hold_next;
  logic [PW-1:0] j_inc;
  logic [PW-1:0] j_dec;

  logic          we;
  logic [IW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [IW-1:0] raddr;

  logic          slot_free;
  logic          load;
  logic [7:0]    ld_char;
  logic          ld_cv;
  logic          ld_last;

  logic [7:0] out_char;
  logic [6:0] out_cur;
  logic [6:0] out_len;
  logic       out_mode;
  logic       out_cv;
  logic       out_last;

  assign j_inc     = j + 1'b1;
  assign j_dec     = j - 1'b1;
  assign slot_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (we) begin
      line_store[waddr] <= wdata;
    end
    if (re) begin
      rdata <= line_store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= leb_pkg::S_IDLE;
      cursor   <= '0;
      length   <= '0;
      ins_mode <= 1'b1;
      j        <= '0;
      emit_len <= '0;
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      length   <= length_next;
      ins_mode <= ins_mode_next;
      j        <= j_next;
      emit_len <= emit_len_next;
    end
  end

  always_ff @(posedge clk) begin
    ch_hold <= ch_hold_next;
  end

  always_comb begin
    state_next    = state;
    cursor_next   = cursor;
    length_next   = length;
    ins_mode_next = ins_mode;
    j_next        = j;
    emit_len_next = emit_len;
    ch_hold_next  = ch_hold;
    q_pop   = 1'b0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = ch_hold;
    re      = 1'b0;
    raddr   = '0;
    load    = 1'b0;
    ld_char = '0;
    ld_cv   = 1'b0;
    ld_last = 1'b1;
    case (state)
      leb_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          ch_hold_next = q_cmd.ch;
          state_next   = leb_pkg::S_STATUS;
          case (q_cmd.op)
            leb_pkg::OP_LEFT: begin
              if (cursor != '0) cursor_next = cursor - 1'b1;
            end
            leb_pkg::OP_RIGHT: begin
              if (cursor < length) cursor_next = cursor + 1'b1;
            end
            leb_pkg::OP_TOGGLE: begin
              ins_mode_next = !ins_mode;
            end
            leb_pkg::OP_DELETE: begin
              if (cursor < length) begin
                j_next     = cursor;
                state_next = leb_pkg::S_DEL_RD;
              end
            end
            leb_pkg::OP_BACK: begin
              if (cursor != '0) begin
                cursor_next = cursor - 1'b1;
                j_next      = cursor - 1'b1;
                state_next  = leb_pkg::S_DEL_RD;
              end
            end
            leb_pkg::OP_TYPE: begin
              if (ins_mode) begin
                if (length < CAP) begin
                  j_next     = length;
                  state_next = leb_pkg::S_INS_RD;
                end
              end else if (cursor < CAP) begin
                we    = 1'b1;
                waddr = cursor[IW-1:0];
                wdata = q_cmd.ch;
                if (cursor == length) length_next = length + 1'b1;
                cursor_next = cursor + 1'b1;
              end
            end
            leb_pkg::OP_EMIT: begin
              cursor_next   = '0;
              length_next   = '0;
              emit_len_next = length;
              j_next        = '0;
              if (length != '0) state_next = leb_pkg::S_EM_RD;
            end
            default: ;
          endcase
        end
      end
      leb_pkg::S_INS_RD: begin
        if (j > cursor) begin
          re         = 1'b1;
          raddr      = j_dec[IW-1:0];
          state_next = leb_pkg::S_INS_WR;
        end else begin
          we          = 1'b1;
          waddr       = cursor[IW-1:0];
          wdata       = ch_hold;
          cursor_next = cursor + 1'b1;
          length_next = length + 1'b1;
          state_next  = leb_pkg::S_STATUS;
        end
      end
      leb_pkg::S_INS_WR: begin
        we         = 1'b1;
        waddr      = j[IW-1:0];
        wdata      = rdata;
        j_next     = j_dec;
        state_next = leb_pkg::S_INS_RD;
      end
      leb_pkg::S_DEL_RD: begin
        if (j_inc < length) begin
          re         = 1'b1;
          raddr      = j_inc[IW-1:0];
          state_next = leb_pkg::S_DEL_WR;
        end else begin
          length_next = length - 1'b1;
          state_next  = leb_pkg::S_STATUS;
        end
      end
      leb_pkg::S_DEL_WR: begin
        we         = 1'b1;
        waddr      = j[IW-1:0];
        wdata      = rdata;
        j_next     = j_inc;
        state_next = leb_pkg::S_DEL_RD;
      end
      leb_pkg::S_EM_RD: begin
        re         = 1'b1;
        raddr      = j[IW-1:0];
        state_next = leb_pkg::S_EM_OUT;
      end
      leb_pkg::S_EM_OUT: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_char    = rdata;
          ld_cv      = 1'b1;
          ld_last    = (j_inc == emit_len);
          j_next     = j_inc;
          state_next = (j_inc == emit_len) ? leb_pkg::S_IDLE : leb_pkg::S_EM_RD;
        end
      end
      leb_pkg::S_STATUS: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = leb_pkg::S_IDLE;
        end
      end
      default: state_next = leb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= ld_char;
      out_cv   <= ld_cv;
      out_last <= ld_last;
      out_cur  <= 7'(cursor);
      out_len  <= 7'(length);
      out_mode <= ins_mode;
    end
  end

  assign m_tdata = {1'b0, out_mode, out_len, out_cur, out_char};
  assign m_tlast = out_last;
  assign m_tuser = out_cv;

endmodule

>>> sv/line_edit_buffer.sv
// Top level of the line edit buffer: front end, command queue, back end.
// Depends on leb_pkg, leb_front, leb_queue and leb_back.

// Key bytes enter on the s_ group, one per word; every byte gives one status word on the
// m_ group, except Escape on a non-empty line, which gives one word per line character
// with tlast on the final one. A two-entry command queue lets bytes be accepted while the
// editor works. The single-port line store sets the timing. A cursor move, mode toggle,
// overwrite or ignored byte shifts nothing in the store; an insert, delete or backspace
// moves each character past the edit point by one entry, with a read and then a write,
// and Escape reads each character before it loads its word. Every byte also passes
// through the queue, and the back end waits while the m_ side holds tready low. The
// line store needs no clearing after reset.

module line_edit_buffer #(
  parameter int LINE_CAPACITY = leb_pkg::LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // key_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // char_out[7:0], cursor_pos[14:8],
                                 // line_length[21:15], shift_insert[22], zero[23]
  output logic        m_tlast,   // is_last
  output logic [0:0]  m_tuser    // line_char_valid[0]
);

  logic          push_valid;
  logic          push_ready;
  leb_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop;
  leb_pkg::cmd_t pop_cmd;

  leb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  leb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  leb_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_pop    (pop),
    .q_cmd    (pop_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

>>> sv/leb_checker.sv
// Port-level checks for the line edit buffer, bound to line_edit_buffer.
// Sees only the top-level ports; no package dependency.

module leb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_status_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0 && m_tlast)
    else $error("status word carries a character or is not last");

  a_emit_cleared: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[14:8] == 7'd0 && m_tdata[21:15] == 7'd0)
    else $error("line character word shows a non-empty line");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[14:8] <= m_tdata[21:15])
    else $error("cursor beyond line length");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);

>>> tb/line_edit_buffer_tb.sv
// Testbench for line_edit_buffer: key bytes in on the s_ stream, line words out on m_.
// Holds its own model of the line, cursor and mode, and checks every output word.
// Depends on leb_pkg and line_edit_buffer.
`timescale 1ns / 100ps

module line_edit_buffer_tb;

  localparam int CAP        = leb_pkg::LINE_CAPACITY_DEF;
  localparam int NUM_KEYS   = 410;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL       = 200;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       last;
    logic [6:0] cur;
    logic [6:0] len;
    logic       mode;
  } line_word_t;

  typedef struct packed {
    logic [7:0] key;
    logic       typed;
    logic [6:0] cur;
    logic [6:0] len;
    logic       mode;
  } key_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;

  logic [7:0]  shadow_line [CAP];
  int          cur_pos = 0;
  int          line_len = 0;
  bit          ins_mode = 1'b1;
  bit          ext_armed = 1'b0;
  line_word_t  pending_words [$];

  int          mismatches = 0;
  int          keys_sent = 0;
  int          idle_cycles = 0;
  int          stall_cnt = 0;
  int          rx_gap;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  line_word_t  got, want;

  localparam int DIRECTED_ROWS = 29;
  key_row_t directed_keys [DIRECTED_ROWS] = '{
    '{leb_pkg::KEY_PREFIX, 1'b1, 7'd0, 7'd0, 1'b1},
    '{leb_pkg::EXT_LEFT,   1'b1, 7'd0, 7'd0, 1'b1},
    '{leb_pkg::KEY_BACK,   1'b1, 7'd0, 7'd0, 1'b1},
    '{leb_pkg::KEY_ESC,    1'b1, 7'd0, 7'd0, 1'b1},
    '{leb_pkg::KEY_PREFIX, 1'b1, 7'd0, 7'd0, 1'b1},
    '{leb_pkg::EXT_RIGHT,  1'b1, 7'd0, 7'd0, 1'b1},
    '{leb_pkg::KEY_PREFIX, 1'b1, 7'd0, 7'd0, 1'b1},
    '{leb_pkg::EXT_DELETE, 1'b1, 7'd0, 7'd0, 1'b1},
    '{leb_pkg::PRINT_LOW,  1'b1, 7'd1, 7'd1, 1'b1},
    '{leb_pkg::PRINT_HIGH, 1'b1, 7'd2, 7'd2, 1'b1},
    '{"A",                 1'b1, 7'd3, 7'd3, 1'b1},
    '{leb_pkg::KEY_PREFIX, 1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::EXT_LEFT,   1'b0, 7'd0, 7'd0, 1'b0},
    '{"B",                 1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::KEY_PREFIX, 1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::EXT_INSERT, 1'b0, 7'd0, 7'd0, 1'b0},
    '{"C",                 1'b0, 7'd0, 7'd0, 1'b0},
    '{"D",                 1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::KEY_PREFIX, 1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::EXT_LEFT,   1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::KEY_PREFIX, 1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::EXT_DELETE, 1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::KEY_BACK,   1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::KEY_PREFIX, 1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::KEY_ESC,    1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::KEY_PREFIX, 1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::KEY_PREFIX, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'd127,              1'b0, 7'd0, 7'd0, 1'b0},
    '{leb_pkg::KEY_ESC,    1'b0, 7'd0, 7'd0, 1'b0}
  };

  line_edit_buffer #(.LINE_CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  task automatic drop_char(input int pos);
    int i;
    for (i = pos; i + 1 < line_len; i++)
      shadow_line[i] = shadow_line[i + 1];
    line_len--;
  endtask

  task automatic edit_line(input logic [7:0] k);
    line_word_t w;
    int i, n;
    if (ext_armed) begin
      ext_armed = 1'b0;
      case (k)
        leb_pkg::EXT_LEFT:   if (cur_pos > 0) cur_pos--;
        leb_pkg::EXT_RIGHT:  if (cur_pos < line_len) cur_pos++;
        leb_pkg::EXT_INSERT: ins_mode = !ins_mode;
        leb_pkg::EXT_DELETE: if (cur_pos < line_len) drop_char(cur_pos);
        default: ;
      endcase
    end else if (k == leb_pkg::KEY_PREFIX) begin
      ext_armed = 1'b1;
    end else if (k == leb_pkg::KEY_ESC) begin
      n = line_len;
      cur_pos = 0;
      line_len = 0;
      for (i = 0; i < n; i++) begin
        w = '{shadow_line[i], 1'b1, 1'(i == n - 1), 7'd0, 7'd0, ins_mode};
        pending_words.push_back(w);
      end
      if (n > 0) return;
    end else if (k == leb_pkg::KEY_BACK) begin
      if (cur_pos > 0) begin
        cur_pos--;
        drop_char(cur_pos);
      end
    end else if (k >= leb_pkg::PRINT_LOW && k <= leb_pkg::PRINT_HIGH) begin
      if (ins_mode) begin
        if (line_len < CAP) begin
          for (i = line_len; i > cur_pos; i--)
            shadow_line[i] = shadow_line[i - 1];
          shadow_line[cur_pos] = k;
          cur_pos++;
          line_len++;
        end
      end else if (cur_pos < CAP) begin
        shadow_line[cur_pos] = k;
        if (cur_pos == line_len) line_len++;
        cur_pos++;
      end
    end
    w = '{8'd0, 1'b0, 1'b1, 7'(cur_pos), 7'(line_len), ins_mode};
    pending_words.push_back(w);
  endtask

  // Called at the edge where the previous word was taken; never lowers and raises valid
  // in the same step.
  task automatic send_key(input logic [7:0] k, input logic typed = 1'b0,
                          input line_word_t typed_word = '0);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= k;
    do @(posedge clk); while (!s_tready);
    edit_line(k);
    if (typed) begin
      void'(pending_words.pop_back());
      pending_words.push_back(typed_word);
    end
    keys_sent++;
  endtask

  task automatic hold_until_drained();
    if (pending_words.size() != 0) begin
      s_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(leb_pkg::PRINT_LOW, leb_pkg::PRINT_HIGH));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b1;
      stall_cnt <= 0;
    end else if (m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tuser[0], m_tlast, m_tdata[14:8], m_tdata[21:15], m_tdata[22]};
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word ch=%0d valid=%0d last=%0d cursor=%0d length=%0d ins=%0d",
                 $time, got.ch, got.valid, got.last, got.cur, got.len, got.mode);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          $display("%0t: expected ch=%0d valid=%0d last=%0d cursor=%0d length=%0d ins=%0d",
                   $time, want.ch, want.valid, want.last, want.cur, want.len, want.mode);
          $display("%0t:   actual ch=%0d valid=%0d last=%0d cursor=%0d length=%0d ins=%0d",
                   $time, got.ch, got.valid, got.last, got.cur, got.len, got.mode);
          mismatches++;
        end
      end
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      rx_gap = rx_calm ? 0 : $urandom_range(0, 19);
      stall_cnt <= rx_gap;
      m_tready  <= (rx_gap == 0);
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_tready  <= (stall_cnt == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int r, n, episode;
    line_word_t typed_word;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_keys[i]) begin
      typed_word = '{8'd0, 1'b0, 1'b1, directed_keys[i].cur, directed_keys[i].len,
                     directed_keys[i].mode};
      send_key(directed_keys[i].key, directed_keys[i].typed, typed_word);
    end
    hold_until_drained();

    episode = 0;
    while (keys_sent < NUM_KEYS) begin
      r = $urandom_range(0, 99);
      if (episode % 60 == 20 || r >= 98) begin
        // fill to capacity, push past it in both modes, then emit the full line
        hold_until_drained();
        if (ext_armed) send_key(8'd0);
        if (!ins_mode) begin
          send_key(leb_pkg::KEY_PREFIX);
          send_key(leb_pkg::EXT_INSERT);
        end
        while (line_len < CAP) send_key(rand_printable());
        repeat (2) send_key(rand_printable());
        send_key(leb_pkg::KEY_PREFIX);
        send_key(leb_pkg::EXT_INSERT);
        while (cur_pos < line_len) begin
          send_key(leb_pkg::KEY_PREFIX);
          send_key(leb_pkg::EXT_RIGHT);
        end
        send_key(rand_printable());
        repeat ($urandom_range(1, 3)) begin
          send_key(leb_pkg::KEY_PREFIX);
          send_key(leb_pkg::EXT_LEFT);
        end
        send_key(rand_printable());
        send_key(leb_pkg::KEY_ESC);
      end else if (r < 40) begin
        repeat ($urandom_range(1, 8)) send_key(rand_printable());
      end else if (r < 60) begin
        repeat ($urandom_range(1, 4)) begin
          send_key(leb_pkg::KEY_PREFIX);
          if ($urandom_range(0, 7) == 0) begin
            send_key(8'($urandom_range(0, 255)));
          end else begin
            case ($urandom_range(0, 3))
              0: send_key(leb_pkg::EXT_LEFT);
              1: send_key(leb_pkg::EXT_RIGHT);
              2: send_key(leb_pkg::EXT_INSERT);
              default: send_key(leb_pkg::EXT_DELETE);
            endcase
          end
        end
      end else if (r < 70) begin
        repeat ($urandom_range(1, 3)) send_key(leb_pkg::KEY_BACK);
      end else if (r < 78) begin
        send_key(leb_pkg::KEY_ESC);
      end else if (r < 90) begin
        n = $urandom_range(1, 3);
        repeat (n) send_key(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(4, 16)) send_key(rand_printable());
      end
      episode++;
    end

    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
